// ===== design/qru_pkg.sv =====
package qru_pkg;

    localparam int ANGLE_BITS          = 20;
    localparam int RATIO_FRACTION_BITS = 16;
    localparam int FITNESS_BITS        = 32;
    localparam int ROT_BITS            = 18;
    localparam int SEED_BITS           = 16;
    localparam int CFG_DATA_BITS       = 18;
    localparam int CFG_INDEX_BITS      = 2;
    localparam int DIR_BITS            = 2;

    localparam int RATIO_BITS = RATIO_FRACTION_BITS + 1;
    localparam int DIV_STEPS  = RATIO_FRACTION_BITS + 1;
    localparam int CNT_BITS   = $clog2(DIV_STEPS);
    localparam int REM_BITS   = FITNESS_BITS + 1;
    localparam int SPAN_BITS  = ROT_BITS + 1;
    localparam int PROD_BITS  = SPAN_BITS + RATIO_BITS + 1;

    localparam logic [SEED_BITS-1:0] LFSR_TAPS = 16'hB400;

    localparam logic [DIR_BITS-1:0] DIR_NONE = 2'd0;
    localparam logic [DIR_BITS-1:0] DIR_POS  = 2'd1;
    localparam logic [DIR_BITS-1:0] DIR_NEG  = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROTATION_LOW  = 2'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ROTATION_HIGH = 2'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_RANDOM_SEED   = 2'd2;

    localparam logic [ROT_BITS-1:0]  ROTATION_LOW_RESET  = 18'd262;
    localparam logic [ROT_BITS-1:0]  ROTATION_HIGH_RESET = 18'd13107;
    localparam logic [SEED_BITS-1:0] SEED_RESET          = 16'd1;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]   theta;
        logic                    qubit_bit;
        logic                    best_bit;
        logic [FITNESS_BITS-1:0] fitness_current;
        logic [FITNESS_BITS-1:0] fitness_best;
    } in_item_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0] new_theta;
        logic [DIR_BITS-1:0]   direction;
        logic                  used_random;
    } out_item_t;

    typedef struct packed {
        logic [ANGLE_BITS-1:0]   theta;
        logic [DIR_BITS-1:0]     direction;
        logic                    used_random;
        logic [FITNESS_BITS-1:0] diff;
        logic [FITNESS_BITS-1:0] max;
    } task_t;

    typedef struct packed {
        logic [ROT_BITS-1:0] rotation_low;
        logic [ROT_BITS-1:0] rotation_high;
    } rot_cfg_t;

    typedef struct packed {
        logic                      valid;
        logic [CFG_INDEX_BITS-1:0] index;
        logic [CFG_DATA_BITS-1:0]  data;
    } cfg_write_t;

endpackage

// ===== design/qru_front.sv =====
module qru_front (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                in_valid,
    input  qru_pkg::in_item_t   in_item,
    input  logic                full,
    input  qru_pkg::cfg_write_t cfg_write,
    output logic                push,
    output qru_pkg::task_t      push_task
);

    logic [qru_pkg::SEED_BITS-1:0]  lfsr_reg;
    logic [qru_pkg::SEED_BITS-1:0]  lfsr_next;
    logic [qru_pkg::SEED_BITS-1:0]  seed;
    logic [1:0]                     quadrant;
    logic                           on_axis;
    logic                           pos;
    logic                           tie;
    logic [qru_pkg::DIR_BITS-1:0]   dir;
    logic                           cur_larger;

    assign push     = in_valid && !full;
    assign quadrant = in_item.theta[qru_pkg::ANGLE_BITS-1 -: 2];
    assign on_axis  = in_item.theta[qru_pkg::ANGLE_BITS-3:0] == '0;
    assign pos      = !quadrant[0];
    assign seed     = cfg_write.data[qru_pkg::SEED_BITS-1:0];

    always_comb
    begin
        tie = 1'b0;
        dir = qru_pkg::DIR_NONE;
        if (in_item.qubit_bit == in_item.best_bit) begin
            dir = qru_pkg::DIR_NONE;
        end else if (!in_item.qubit_bit) begin
            if (!on_axis) begin
                dir = pos ? qru_pkg::DIR_POS : qru_pkg::DIR_NEG;
            end else if (quadrant[0]) begin
                dir = qru_pkg::DIR_NONE;
            end else begin
                tie = 1'b1;
            end
        end else begin
            if (!on_axis) begin
                dir = pos ? qru_pkg::DIR_NEG : qru_pkg::DIR_POS;
            end else if (!quadrant[0]) begin
                dir = qru_pkg::DIR_NONE;
            end else begin
                tie = 1'b1;
            end
        end
        if (tie) begin
            dir = lfsr_reg[0] ? qru_pkg::DIR_NEG : qru_pkg::DIR_POS;
        end
    end

    always_comb
    begin
        lfsr_next = lfsr_reg;
        if (cfg_write.valid && cfg_write.index == qru_pkg::CFG_RANDOM_SEED) begin
            lfsr_next = (seed == '0) ? qru_pkg::SEED_BITS'(1) : seed;
        end else if (push && tie) begin
            lfsr_next = (lfsr_reg >> 1) ^ (lfsr_reg[0] ? qru_pkg::LFSR_TAPS : '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            lfsr_reg <= qru_pkg::SEED_RESET;
        end else begin
            lfsr_reg <= lfsr_next;
        end
    end

    assign cur_larger = in_item.fitness_current > in_item.fitness_best;

    always_comb
    begin
        push_task.theta       = in_item.theta;
        push_task.direction   = dir;
        push_task.used_random = tie;
        push_task.max  = cur_larger ? in_item.fitness_current : in_item.fitness_best;
        push_task.diff = cur_larger ? in_item.fitness_current - in_item.fitness_best
                                    : in_item.fitness_best - in_item.fitness_current;
    end

endmodule

// ===== design/qru_queue.sv =====
module qru_queue (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           push,
    input  qru_pkg::task_t push_task,
    input  logic           pop,
    output logic           full,
    output logic           not_empty,
    output qru_pkg::task_t pop_task
);

    qru_pkg::task_t entry_reg [2];
    logic           wr_ptr_reg;
    logic           wr_ptr_next;
    logic           rd_ptr_reg;
    logic           rd_ptr_next;
    logic [1:0]     count_reg;
    logic [1:0]     count_next;
    logic           do_push;
    logic           do_pop;

    assign full      = count_reg == 2'd2;
    assign not_empty = count_reg != 2'd0;
    assign do_push   = push && !full;
    assign do_pop    = pop && not_empty;
    assign pop_task  = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = do_push ? !wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? !rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg;
        if (do_push && !do_pop) begin
            count_next = count_reg + 2'd1;
        end else if (do_pop && !do_push) begin
            count_next = count_reg - 2'd1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push) begin
            entry_reg[wr_ptr_reg] <= push_task;
        end
    end

endmodule

// ===== design/qru_back.sv =====
module qru_back (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              not_empty,
    input  qru_pkg::task_t    pop_task,
    input  qru_pkg::rot_cfg_t rot_cfg,
    input  logic              out_stall,
    output logic              pop,
    output logic              out_valid,
    output qru_pkg::out_item_t out_item
);

    typedef enum logic [3:0] {
        ST_IDLE = 4'b0001,
        ST_DIV  = 4'b0010,
        ST_MUL  = 4'b0100,
        ST_SUM  = 4'b1000
    } state_t;

    state_t                                state_reg;
    state_t                                state_next;
    logic [qru_pkg::CNT_BITS-1:0]          cnt_reg;
    logic [qru_pkg::CNT_BITS-1:0]          cnt_next;
    logic [qru_pkg::REM_BITS-1:0]          rem_reg;
    logic [qru_pkg::REM_BITS-1:0]          rem_next;
    logic [qru_pkg::FITNESS_BITS-1:0]      den_reg;
    logic [qru_pkg::RATIO_BITS-1:0]        quot_reg;
    logic [qru_pkg::RATIO_BITS-1:0]        quot_next;
    logic                                  zero_reg;
    logic [qru_pkg::ANGLE_BITS-1:0]        theta_reg;
    logic [qru_pkg::DIR_BITS-1:0]          dir_reg;
    logic                                  used_reg;
    logic signed [qru_pkg::PROD_BITS-1:0]  prod_reg;
    logic                                  out_valid_reg;
    logic                                  out_valid_next;
    qru_pkg::out_item_t                    out_item_reg;

    logic [qru_pkg::REM_BITS-1:0]          rem_shift;
    logic                                  ge;
    logic [qru_pkg::RATIO_BITS-1:0]        ratio;
    logic signed [qru_pkg::SPAN_BITS-1:0]  span;
    logic [qru_pkg::ROT_BITS-1:0]          rot;
    logic [qru_pkg::ANGLE_BITS-1:0]        delta;
    logic [qru_pkg::ANGLE_BITS-1:0]        new_theta;
    logic                                  out_free;
    logic                                  load_out;

    localparam logic [qru_pkg::RATIO_BITS-1:0] ONE =
        qru_pkg::RATIO_BITS'(1) << qru_pkg::RATIO_FRACTION_BITS;
    localparam logic [qru_pkg::CNT_BITS-1:0] LAST_STEP =
        qru_pkg::CNT_BITS'(qru_pkg::DIV_STEPS - 1);

    assign out_free = !out_valid_reg || !out_stall;
    assign pop      = (state_reg == ST_IDLE) && not_empty;
    assign load_out = (state_reg == ST_SUM) && out_free;

    assign rem_shift = (cnt_reg == '0) ? rem_reg : (rem_reg << 1);
    assign ge        = rem_shift >= {1'b0, den_reg};
    assign rem_next  = ge ? rem_shift - {1'b0, den_reg} : rem_shift;
    assign quot_next = {quot_reg[qru_pkg::RATIO_BITS-2:0], ge};

    assign ratio = zero_reg ? '0 : ((quot_reg > ONE) ? ONE : quot_reg);
    assign span  = $signed({1'b0, rot_cfg.rotation_high})
                 - $signed({1'b0, rot_cfg.rotation_low});

    assign rot   = rot_cfg.rotation_low
                 + prod_reg[qru_pkg::RATIO_FRACTION_BITS +: qru_pkg::ROT_BITS];
    assign delta = qru_pkg::ANGLE_BITS'({rot, 1'b0});

    always_comb
    begin
        case (dir_reg)
            qru_pkg::DIR_POS: new_theta = theta_reg + delta;
            qru_pkg::DIR_NEG: new_theta = theta_reg - delta;
            default:          new_theta = theta_reg;
        endcase
    end

    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                cnt_next = '0;
                if (not_empty) begin
                    state_next = ST_DIV;
                end
            end
            ST_DIV:
            begin
                cnt_next = cnt_reg + qru_pkg::CNT_BITS'(1);
                if (cnt_reg == LAST_STEP) begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:
            begin
                state_next = ST_SUM;
            end
            ST_SUM:
            begin
                if (out_free) begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg && out_stall;
        if (load_out) begin
            out_valid_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop) begin
            rem_reg   <= {1'b0, pop_task.diff};
            den_reg   <= pop_task.max;
            quot_reg  <= '0;
            zero_reg  <= pop_task.max == '0;
            theta_reg <= pop_task.theta;
            dir_reg   <= pop_task.direction;
            used_reg  <= pop_task.used_random;
        end else if (state_reg == ST_DIV) begin
            rem_reg  <= rem_next;
            quot_reg <= quot_next;
        end
        if (state_reg == ST_MUL) begin
            prod_reg <= span * $signed({1'b0, ratio});
        end
        if (load_out) begin
            out_item_reg.new_theta   <= new_theta;
            out_item_reg.direction   <= dir_reg;
            out_item_reg.used_random <= used_reg;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_item  = out_item_reg;

endmodule

// ===== design/qubit_rotation_update.sv =====
// Qubit rotation update.
// Input channel (in_valid, in_stall, in_item): a transaction is taken when in_valid is high
// and in_stall low. The front classifies the rotation direction, steps the tie-break LFSR
// and forms the fitness difference and maximum, then queues the work (two entries).
// The back runs a restoring division of difference by maximum, one quotient bit a cycle,
// one signed multiply for the blend of low and high, then the angle add.
// Output channel (out_valid, out_stall, out_item): a registered result is held while
// out_stall is high; the back finishes its next item and waits behind it.
// The back takes one transaction at a time and pops the next only when back in idle.
// An input transaction passes the queue, then the back states idle, divide, multiply, sum.
// Configuration (cfg_valid, cfg_ready, cfg_index, cfg_data): cfg_ready is always high;
// index 0 rotation low, 1 rotation high, 2 seed (reloads the LFSR, zero loads as one).
// Reset clears the queue, the back's state and the output valid, loads low 262, high 13107
// and an LFSR of one.
module qubit_rotation_update (
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  in_valid,
    output logic                                  in_stall,
    input  qru_pkg::in_item_t                     in_item,
    output logic                                  out_valid,
    input  logic                                  out_stall,
    output qru_pkg::out_item_t                    out_item,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [qru_pkg::CFG_INDEX_BITS-1:0]    cfg_index,
    input  logic [qru_pkg::CFG_DATA_BITS-1:0]     cfg_data
);

    logic [qru_pkg::ROT_BITS-1:0] rotation_low_reg;
    logic [qru_pkg::ROT_BITS-1:0] rotation_high_reg;
    qru_pkg::cfg_write_t          cfg_write;
    qru_pkg::rot_cfg_t            rot_cfg;
    qru_pkg::task_t               push_task;
    qru_pkg::task_t               pop_task;
    logic                         push;
    logic                         pop;
    logic                         full;
    logic                         not_empty;

    assign cfg_ready       = 1'b1;
    assign cfg_write.valid = cfg_valid && cfg_ready;
    assign cfg_write.index = cfg_index;
    assign cfg_write.data  = cfg_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            rotation_low_reg  <= qru_pkg::ROTATION_LOW_RESET;
            rotation_high_reg <= qru_pkg::ROTATION_HIGH_RESET;
        end else if (cfg_write.valid) begin
            if (cfg_index == qru_pkg::CFG_ROTATION_LOW) begin
                rotation_low_reg <= cfg_data[qru_pkg::ROT_BITS-1:0];
            end
            if (cfg_index == qru_pkg::CFG_ROTATION_HIGH) begin
                rotation_high_reg <= cfg_data[qru_pkg::ROT_BITS-1:0];
            end
        end
    end

    assign rot_cfg.rotation_low  = rotation_low_reg;
    assign rot_cfg.rotation_high = rotation_high_reg;
    assign in_stall              = full;

    qru_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_item   (in_item),
        .full      (full),
        .cfg_write (cfg_write),
        .push      (push),
        .push_task (push_task)
    );

    qru_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_task (push_task),
        .pop       (pop),
        .full      (full),
        .not_empty (not_empty),
        .pop_task  (pop_task)
    );

    qru_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .not_empty (not_empty),
        .pop_task  (pop_task),
        .rot_cfg   (rot_cfg),
        .out_stall (out_stall),
        .pop       (pop),
        .out_valid (out_valid),
        .out_item  (out_item)
    );

`ifndef NO_ASSERTIONS
    a_pop_needs_entry: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> not_empty)
        else $error("pop from empty queue");

    a_random_has_direction: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_item.used_random) |->
        (out_item.direction == qru_pkg::DIR_POS || out_item.direction == qru_pkg::DIR_NEG))
        else $error("tie-break result without direction");

    a_direction_legal: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_item.direction == qru_pkg::DIR_NONE
            || out_item.direction == qru_pkg::DIR_POS
            || out_item.direction == qru_pkg::DIR_NEG))
        else $error("illegal direction code");

    a_push_when_space: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !full)
        else $error("push into full queue");
`endif

endmodule

// ===== test/tb.sv =====
module tb;
    import qru_pkg::*;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_UNUSED = 2'd3;
    localparam logic [ANGLE_BITS-1:0] ANGLE_PI  = ANGLE_BITS'(1) << (ANGLE_BITS - 2);
    localparam logic [ANGLE_BITS-1:0] ANGLE_MAX = '1;
    localparam logic [FITNESS_BITS-1:0] FIT_MAX = '1;
    localparam longint unsigned RATIO_ONE = 64'd1 << RATIO_FRACTION_BITS;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic in_valid = 1'b0;
    logic in_stall;
    in_item_t in_item = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    out_item_t out_item;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;

    qubit_rotation_update dut (
        .clk(clk),
        .rst_n(rst_n),
        .in_valid(in_valid),
        .in_stall(in_stall),
        .in_item(in_item),
        .out_valid(out_valid),
        .out_stall(out_stall),
        .out_item(out_item),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    always #2 clk = ~clk;

    logic [ROT_BITS-1:0] step_low = ROTATION_LOW_RESET;
    logic [ROT_BITS-1:0] step_high = ROTATION_HIGH_RESET;
    logic [SEED_BITS-1:0] tie_state = SEED_RESET;

    in_item_t qubit_feed[$];
    out_item_t expected_updates[$];
    int items_queued = 0;
    int results_seen = 0;
    int errors = 0;
    int send_idle_pct = 0;
    int stall_pct = 0;
    int hold_requests = 0;
    logic in_fire = 1'b0;

    function automatic out_item_t rotate_qubit(in_item_t it);
        out_item_t res;
        logic [FITNESS_BITS-1:0] fmax;
        logic [FITNESS_BITS-1:0] fdiff;
        longint unsigned ratio;
        longint unsigned step;
        logic [ANGLE_BITS-1:0] delta;
        logic [1:0] quad;
        logic on_axis;
        logic tie;
        logic shifted;
        fmax = (it.fitness_current > it.fitness_best) ? it.fitness_current : it.fitness_best;
        fdiff = (it.fitness_current > it.fitness_best) ?
                it.fitness_current - it.fitness_best : it.fitness_best - it.fitness_current;
        if (fmax == '0)
            step = 64'(step_low);
        else
        begin
            ratio = (64'(fdiff) << RATIO_FRACTION_BITS) / 64'(fmax);
            if (ratio > RATIO_ONE)
                ratio = RATIO_ONE;
            step = (64'(step_low) * (RATIO_ONE - ratio) + 64'(step_high) * ratio)
                   >> RATIO_FRACTION_BITS;
        end
        delta = ANGLE_BITS'(step << 1);
        quad = it.theta[ANGLE_BITS-1 -: 2];
        on_axis = (it.theta[ANGLE_BITS-3:0] == '0);
        tie = 1'b0;
        res.used_random = 1'b0;
        if (it.qubit_bit == it.best_bit)
            res.direction = DIR_NONE;
        else if (!on_axis)
            res.direction = ((!quad[0]) ^ it.qubit_bit) ? DIR_POS : DIR_NEG;
        else if (quad[0] ^ it.qubit_bit)
            res.direction = DIR_NONE;
        else
            tie = 1'b1;
        if (tie)
        begin
            shifted = tie_state[0];
            tie_state = tie_state >> 1;
            if (shifted)
                tie_state = tie_state ^ LFSR_TAPS;
            res.direction = shifted ? DIR_NEG : DIR_POS;
            res.used_random = 1'b1;
        end
        if (res.direction == DIR_POS)
            res.new_theta = it.theta + delta;
        else if (res.direction == DIR_NEG)
            res.new_theta = it.theta - delta;
        else
            res.new_theta = it.theta;
        return res;
    endfunction

    function automatic in_item_t qubit_item(logic [ANGLE_BITS-1:0] th, logic qb, logic bb,
                                            logic [FITNESS_BITS-1:0] fc,
                                            logic [FITNESS_BITS-1:0] fb);
        in_item_t it;
        it.theta = th;
        it.qubit_bit = qb;
        it.best_bit = bb;
        it.fitness_current = fc;
        it.fitness_best = fb;
        return it;
    endfunction

    function automatic in_item_t random_qubit_item();
        in_item_t it;
        it.theta = ANGLE_BITS'($urandom);
        case ($urandom_range(0, 7))
            0, 1: it.theta[ANGLE_BITS-3:0] = '0;
            2: it.theta = {it.theta[ANGLE_BITS-1 -: 2], {(ANGLE_BITS-2){1'b0}}} + 1'b1;
            3: it.theta = {it.theta[ANGLE_BITS-1 -: 2], {(ANGLE_BITS-2){1'b0}}} - 1'b1;
            default: ;
        endcase
        it.qubit_bit = 1'($urandom);
        it.best_bit = 1'($urandom);
        it.fitness_current = $urandom;
        it.fitness_best = $urandom;
        case ($urandom_range(0, 11))
            0: it.fitness_best = it.fitness_current;
            1: it.fitness_current = '0;
            2: it.fitness_best = '0;
            3:
            begin
                it.fitness_current = '0;
                it.fitness_best = '0;
            end
            4:
            begin
                it.fitness_current = $urandom_range(0, 15);
                it.fitness_best = $urandom_range(0, 15);
            end
            5: it.fitness_best = it.fitness_current + $urandom_range(0, 255);
            6: it.fitness_current = it.fitness_current >> $urandom_range(0, 31);
            7: it.fitness_best = it.fitness_best >> $urandom_range(0, 31);
            default: ;
        endcase
        return it;
    endfunction

    always @(negedge clk)
    begin
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_fire)
        begin
            if (qubit_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                in_valid <= 1'b1;
                in_item <= qubit_feed.pop_front();
            end
            else
                in_valid <= 1'b0;
        end
    end

    int hold_left = 0;
    int holds_served = 0;

    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left <= hold_left - 1;
        end
        else if (hold_requests != holds_served)
        begin
            holds_served <= holds_served + 1;
            hold_left <= 400;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    always @(posedge clk)
    begin
        out_item_t want;
        if (!rst_n)
            in_fire <= 1'b0;
        else
        begin
            in_fire <= in_valid && !in_stall;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    CFG_ROTATION_LOW: step_low = cfg_data[ROT_BITS-1:0];
                    CFG_ROTATION_HIGH: step_high = cfg_data[ROT_BITS-1:0];
                    CFG_RANDOM_SEED:
                        tie_state = (cfg_data[SEED_BITS-1:0] == '0) ?
                                    SEED_BITS'(1) : cfg_data[SEED_BITS-1:0];
                    default: ;
                endcase
            end
            if (in_valid && !in_stall)
                expected_updates.push_back(rotate_qubit(in_item));
            if (out_valid && !out_stall)
            begin
                results_seen++;
                if (expected_updates.size() == 0)
                begin
                    $error("unexpected result transaction: %h", out_item);
                    errors++;
                end
                else
                begin
                    want = expected_updates.pop_front();
                    if (out_item.new_theta !== want.new_theta)
                    begin
                        $error("new_theta: expected %0d, got %0d",
                               want.new_theta, out_item.new_theta);
                        errors++;
                    end
                    if (out_item.direction !== want.direction)
                    begin
                        $error("direction: expected %0d, got %0d",
                               want.direction, out_item.direction);
                        errors++;
                    end
                    if (out_item.used_random !== want.used_random)
                    begin
                        $error("used_random: expected %0d, got %0d",
                               want.used_random, out_item.used_random);
                        errors++;
                    end
                end
            end
        end
    end

    task automatic write_reg(logic [CFG_INDEX_BITS-1:0] idx, logic [CFG_DATA_BITS-1:0] value);
        @(negedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        do
            @(posedge clk);
        while (!cfg_ready);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    task automatic await_results();
        while (results_seen < items_queued)
            @(negedge clk);
    endtask

    task automatic run_batch(int count, int idle_pct, int stall_chance, bit squeeze);
        send_idle_pct = idle_pct;
        stall_pct = stall_chance;
        @(posedge clk);
        for (int i = 0; i < count; i++)
            qubit_feed.push_back(random_qubit_item());
        items_queued += count;
        if (squeeze)
            hold_requests++;
        await_results();
    endtask

    task automatic write_seed(logic [SEED_BITS-1:0] seed);
        write_reg(CFG_RANDOM_SEED, {2'($urandom), seed});
    endtask

    initial
    begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        @(posedge clk);
        qubit_feed.push_back(qubit_item('0, 1'b0, 1'b1, 32'd100, 32'd50));
        qubit_feed.push_back(qubit_item('0, 1'b1, 1'b0, 32'd100, 32'd50));
        qubit_feed.push_back(qubit_item(ANGLE_PI, 1'b0, 1'b1, '0, '0));
        qubit_feed.push_back(qubit_item(ANGLE_PI, 1'b1, 1'b0, '0, '0));
        qubit_feed.push_back(qubit_item(ANGLE_BITS'(2 * ANGLE_PI), 1'b0, 1'b1, 32'd5, '0));
        qubit_feed.push_back(qubit_item(ANGLE_BITS'(3 * ANGLE_PI), 1'b1, 1'b0, '0, 32'd7));
        qubit_feed.push_back(qubit_item(ANGLE_BITS'(2 * ANGLE_PI), 1'b1, 1'b0, 32'd9, 32'd3));
        qubit_feed.push_back(qubit_item(ANGLE_BITS'(3 * ANGLE_PI), 1'b0, 1'b1, 32'd3, 32'd9));
        qubit_feed.push_back(qubit_item(ANGLE_MAX, 1'b0, 1'b1, FIT_MAX, FIT_MAX));
        qubit_feed.push_back(qubit_item(ANGLE_MAX, 1'b1, 1'b0, FIT_MAX, '0));
        qubit_feed.push_back(qubit_item(20'd1, 1'b0, 1'b1, 32'd1, FIT_MAX));
        qubit_feed.push_back(qubit_item(20'd1, 1'b1, 1'b0, FIT_MAX, 32'd1));
        qubit_feed.push_back(qubit_item(ANGLE_BITS'(ANGLE_PI + 1), 1'b0, 1'b1,
                                        32'd123456, 32'd654321));
        qubit_feed.push_back(qubit_item(ANGLE_BITS'(ANGLE_PI - 1), 1'b1, 1'b0,
                                        32'd654321, 32'd123456));
        qubit_feed.push_back(qubit_item(ANGLE_BITS'(2 * ANGLE_PI + 5), 1'b0, 1'b1,
                                        32'd1000, 32'd999));
        qubit_feed.push_back(qubit_item(ANGLE_BITS'(3 * ANGLE_PI + 9), 1'b1, 1'b0,
                                        32'd999, 32'd1000));
        qubit_feed.push_back(qubit_item('0, 1'b0, 1'b0, FIT_MAX, 32'd1));
        qubit_feed.push_back(qubit_item(ANGLE_MAX, 1'b1, 1'b1, 32'd1, FIT_MAX));
        qubit_feed.push_back(qubit_item(20'h55555, 1'b0, 1'b1, 32'hAAAAAAAA, 32'h55555555));
        qubit_feed.push_back(qubit_item(20'hAAAAA, 1'b1, 1'b0, 32'h55555555, 32'hAAAAAAAA));
        for (int i = 0; i < 4; i++)
            qubit_feed.push_back(qubit_item('0, 1'b0, 1'b1, 32'd40, 32'd80));
        items_queued += 24;
        await_results();

        write_reg(CFG_ROTATION_LOW, '0);
        write_reg(CFG_ROTATION_HIGH, 18'h3FFFF);
        write_seed(16'hFFFF);
        run_batch(300, 0, 0, 1'b1);

        write_reg(CFG_ROTATION_LOW, 18'h3FFFF);
        write_reg(CFG_ROTATION_HIGH, '0);
        write_seed('0);
        run_batch(300, 59, 0, 1'b0);

        write_reg(CFG_ROTATION_LOW, CFG_DATA_BITS'($urandom_range(0, 262143)));
        write_reg(CFG_ROTATION_HIGH, CFG_DATA_BITS'($urandom_range(0, 262143)));
        write_seed(SEED_BITS'($urandom_range(1, 65535)));
        write_reg(CFG_UNUSED, CFG_DATA_BITS'($urandom));
        run_batch(300, 0, 59, 1'b0);

        write_reg(CFG_ROTATION_LOW, CFG_DATA_BITS'($urandom_range(0, 4095)));
        write_reg(CFG_ROTATION_HIGH, CFG_DATA_BITS'($urandom_range(0, 262143)));
        run_batch(300, 20, 20, 1'b0);

        write_reg(CFG_ROTATION_LOW, '0);
        write_reg(CFG_ROTATION_HIGH, '0);
        write_seed(16'h8000);
        run_batch(200, 0, 0, 1'b0);

        write_reg(CFG_ROTATION_LOW, CFG_DATA_BITS'($urandom_range(0, 262143)));
        write_reg(CFG_ROTATION_HIGH, CFG_DATA_BITS'($urandom_range(0, 262143)));
        write_seed(SEED_BITS'($urandom_range(1, 65535)));
        run_batch(300, 10, 30, 1'b1);

        write_reg(CFG_ROTATION_LOW, ROTATION_LOW_RESET);
        write_reg(CFG_ROTATION_HIGH, ROTATION_HIGH_RESET);
        write_seed(SEED_RESET);
        run_batch(250, 0, 0, 1'b0);

        repeat (60) @(negedge clk);
        if (expected_updates.size() != 0)
        begin
            $error("%0d result transactions never arrived", expected_updates.size());
            errors++;
        end
        if (errors == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #3000000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

// ===== files.f =====
design/qru_pkg.sv
design/qru_front.sv
design/qru_queue.sv
design/qru_back.sv
design/qubit_rotation_update.sv
test/tb.sv
